@@ design/lqmdu_pkg.sv @@
// shared constants and types for the link quality mix and decay update
`timescale 1ns / 1ps

package lqmdu_pkg;

	// quantity, flow and rate formats
	localparam int QTY_W     = 40;
	localparam int HALF_W    = QTY_W / 2;
	localparam int FLOW_W    = QTY_W + 1;
	localparam int RATE_W    = 32;
	localparam int DT_W      = 32;
	localparam int DT_FRAC   = 16;
	localparam int RATE_FRAC = 32;
	localparam int DFAC_W    = RATE_FRAC + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = QTY_W;

	localparam logic [QTY_W-1:0]  QTY_MAX  = {QTY_W{1'b1}};
	localparam logic [DFAC_W-1:0] RATE_ONE = {1'b1, {RATE_FRAC{1'b0}}};

	// register reset values
	localparam logic [DT_W-1:0]  RST_TIME_STEP   = 32'd65536;
	localparam logic [QTY_W-1:0] RST_ZERO_VOLUME = 40'd2314;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_STEP   = 2'd0,
		REG_STEADY_MODE = 2'd1,
		REG_ZERO_VOLUME = 2'd2
	} reg_idx_t;

	// routing case reported with each result
	typedef enum logic [1:0] {
		CASE_STEADY = 2'd0,
		CASE_NOFLOW = 2'd1,
		CASE_DRY    = 2'd2,
		CASE_MIX    = 2'd3
	} case_t;

endpackage

@@ design/lqmdu_div.sv @@
// pipelined restoring divider, one quotient bit per stage, saturating quotient
`timescale 1ns / 1ps

module lqmdu_div #(
	parameter int NUM_W  = 80,
	parameter int DEN_W  = 40,
	parameter int QUO_W  = lqmdu_pkg::QTY_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	localparam int HI_W  = NUM_W - QUO_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [CMP_W-1:0]  hi_x;
	logic [CMP_W-1:0]  den_x;

	logic              vld_s  [QUO_W+1];
	logic [DEN_W-1:0]  rem_s  [QUO_W+1];
	logic [QUO_W-1:0]  nq_s   [QUO_W+1];
	logic [DEN_W-1:0]  den_s  [QUO_W+1];
	logic              ovf_s  [QUO_W+1];
	logic [SIDE_W-1:0] side_s [QUO_W+1];

	// quotient overflows when the upper numerator part already reaches the divisor
	assign hi_x  = CMP_W'(num[NUM_W-1:QUO_W]);
	assign den_x = CMP_W'(den);

	// entry stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// entry stage payload
	always_ff @(posedge clk) begin
		rem_s[0]  <= DEN_W'(num[NUM_W-1:QUO_W]);
		nq_s[0]   <= num[QUO_W-1:0];
		den_s[0]  <= den;
		ovf_s[0]  <= (hi_x >= den_x);
		side_s[0] <= side_in;
	end

	// one trial subtraction per stage, numerator bits shift out as quotient bits shift in
	for (genvar j = 1; j <= QUO_W; j++) begin : g_step
		logic [DEN_W:0] trial;
		logic           fit;

		always_comb begin
			trial = {rem_s[j-1], nq_s[j-1][QUO_W-1]};
			fit   = (trial >= {1'b0, den_s[j-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j]  <= fit ? DEN_W'(trial - {1'b0, den_s[j-1]}) : trial[DEN_W-1:0];
			nq_s[j]   <= {nq_s[j-1][QUO_W-2:0], fit};
			den_s[j]  <= den_s[j-1];
			ovf_s[j]  <= ovf_s[j-1];
			side_s[j] <= side_s[j-1];
		end
	end

	// saturate on overflow
	assign out_valid = vld_s[QUO_W];
	assign quo       = ovf_s[QUO_W] ? {QUO_W{1'b1}} : nq_s[QUO_W];
	assign side_out  = side_s[QUO_W];

endmodule

@@ design/link_quality_mix_decay_update_top.sv @@
// top level of the link quality mix and decay update pipeline
//
// channel   direction  handshake             payload
// start     in         start & !busy         link_flow .. steady_decay
// result    out        done (one cycle)      link_conc_new, case_taken
// config    in         cfg_valid & cfg_ready cfg_index, cfg_data
//
// one transaction enters per cycle; busy stays low
// a result passes through two 41-stage divider pipelines
// (growth and evaporation quotients in parallel, then the mixing quotient) plus
// three stages ahead of them, five between them and the output register
// reset clears all valid bits and loads the register defaults; no clearing pass
// the receiver cannot stall, so the pipeline never holds
`timescale 1ns / 1ps

module link_quality_mix_decay_update_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [lqmdu_pkg::FLOW_W-1:0]  link_flow,
	input  logic [lqmdu_pkg::QTY_W-1:0]          link_volume_old,
	input  logic [lqmdu_pkg::QTY_W-1:0]          link_volume_new,
	input  logic [lqmdu_pkg::QTY_W-1:0]          link_conc_old,
	input  logic [lqmdu_pkg::QTY_W-1:0]          conc_end_one,
	input  logic [lqmdu_pkg::QTY_W-1:0]          conc_end_two,
	input  logic [lqmdu_pkg::RATE_W-1:0]         decay_rate,
	input  logic [lqmdu_pkg::QTY_W-1:0]          evap_loss,
	input  logic [lqmdu_pkg::RATE_W-1:0]         steady_decay,
	output logic                                 done,
	output logic [lqmdu_pkg::QTY_W-1:0]          link_conc_new,
	output logic [1:0]                           case_taken,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lqmdu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lqmdu_pkg::CFG_DAT_W-1:0]      cfg_data
);

	localparam int QW = lqmdu_pkg::QTY_W;
	localparam int HW = lqmdu_pkg::HALF_W;
	localparam int DW = lqmdu_pkg::DT_W;
	localparam int RW = lqmdu_pkg::RATE_W;
	localparam int FW = lqmdu_pkg::DFAC_W;

	// sideband carried through the dividers
	typedef struct packed {
		lqmdu_pkg::case_t cs;
		logic [QW-1:0]    cup;
		logic [QW-1:0]    csel;
		logic [QW-1:0]    vold;
		logic             use_evap;
		logic [FW-1:0]    dfac;
		logic             knz;
		logic [RW-1:0]    sdec;
	} side_e_t;

	typedef struct packed {
		logic [QW-1:0] q;
		logic          grow_en;
	} side_g_t;

	typedef struct packed {
		lqmdu_pkg::case_t cs;
		logic [QW-1:0]    early;
		logic             use_early;
	} side_m_t;

	// saturating add of two quantities
	function automatic logic [QW-1:0] add_sat(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [QW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[QW] ? lqmdu_pkg::QTY_MAX : s[QW-1:0];
	endfunction

	// configuration registers
	logic [DW-1:0] time_step_q;
	logic          steady_mode_q;
	logic [QW-1:0] zero_volume_q;

	// input decode
	logic [QW:0]      flow_u;
	logic [QW:0]      flow_abs;
	logic             neg;
	logic [QW-1:0]    q_in;
	logic [QW-1:0]    cup_in;
	lqmdu_pkg::case_t cs_in;

	// stage 1
	logic             v_s1;
	lqmdu_pkg::case_t cs_s1;
	logic [QW-1:0]    q_s1, cup_s1, csel_s1, vold_s1, diff_s1;
	logic             grow_en_s1, vold_gt_s1, knz_s1;
	logic [HW+DW-1:0] epl_s1, eph_s1;
	logic [2*RW-1:0]  kdt_s1;
	logic [RW-1:0]    sdec_s1;

	// stage 2
	logic              v_s2;
	lqmdu_pkg::case_t  cs_s2;
	logic [QW-1:0]     q_s2, cup_s2, csel_s2, vold_s2, diff_s2, vevap_s2;
	logic              grow_en_s2, use_evap_s2, knz_s2;
	logic [FW-1:0]     dfac_s2;
	logic [RW-1:0]     sdec_s2;
	logic [QW+DW-1:0]  ev_full;
	logic [QW-1:0]     vevap_c;
	logic [2*RW-lqmdu_pkg::DT_FRAC-1:0] kdt_c;
	logic [FW-1:0]     dfac_c;

	// stage 3
	logic             v_s3;
	lqmdu_pkg::case_t cs_s3;
	logic [QW-1:0]    q_s3, cup_s3, csel_s3, vold_s3, diff_s3;
	logic             grow_en_s3, use_evap_s3, knz_s3;
	logic [FW-1:0]    dfac_s3;
	logic [RW-1:0]    sdec_s3;
	logic [HW+QW-1:0] cvl_s3, cvh_s3;

	// divider connections
	logic [2*QW-1:0]   e_num;
	logic [QW+16-1:0]  g_num;
	side_e_t           e_side_in, e_side_out;
	side_g_t           g_side_in, g_side_out;
	logic              e_valid, g_valid;
	logic [QW-1:0]     e_quo, g_quo;

	// stage 5
	logic             v_s5;
	lqmdu_pkg::case_t cs_s5;
	logic [QW-1:0]    c1_s5, qin_s5, cup_s5, vold_s5;
	logic [FW-1:0]    dfac_s5;
	logic             knz_s5;
	logic [RW-1:0]    sdec_s5;
	logic [FW-1:0]    fac_c;

	// stage 6
	logic             v_s6;
	lqmdu_pkg::case_t cs_s6;
	logic [QW-1:0]    c1_s6, cup_s6, vold_s6;
	logic             knz_s6;
	logic [HW+FW-1:0] cpl_s6, cph_s6;
	logic [HW+DW-1:0] qpl_s6, qph_s6;

	// stage 7
	logic             v_s7;
	lqmdu_pkg::case_t cs_s7;
	logic [QW-1:0]    c1_s7, cup_s7, vold_s7, c2_s7, vin_s7;
	logic             knz_s7;
	logic [QW+FW-1:0] cp_full;
	logic [QW+DW-1:0] qp_full;

	// stage 8
	logic             v_s8;
	lqmdu_pkg::case_t cs_s8;
	logic [QW:0]      denom_s8;
	logic [QW-1:0]    early_s8;
	logic [HW+QW-1:0] pal_s8, pah_s8, pbl_s8, pbh_s8;
	logic [QW-1:0]    early_c;

	// stage 9
	logic             v_s9;
	lqmdu_pkg::case_t cs_s9;
	logic [QW:0]      denom_s9;
	logic [QW-1:0]    early_s9;
	logic             use_early_s9;
	logic [2*QW-1:0]  pa_s9, pb_s9;

	// mixing divider and output
	logic [2*QW:0] m_num;
	side_m_t       m_side_in, m_side_out;
	logic          m_valid;
	logic [QW-1:0] m_quo;
	logic          done_q;
	logic [QW-1:0] conc_q;
	logic [1:0]    case_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= lqmdu_pkg::RST_TIME_STEP;
			steady_mode_q <= 1'b0;
			zero_volume_q <= lqmdu_pkg::RST_ZERO_VOLUME;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lqmdu_pkg::reg_idx_t'(cfg_index))
				lqmdu_pkg::REG_TIME_STEP:   time_step_q   <= cfg_data[DW-1:0];
				lqmdu_pkg::REG_STEADY_MODE: steady_mode_q <= cfg_data[0];
				lqmdu_pkg::REG_ZERO_VOLUME: zero_volume_q <= cfg_data[QW-1:0];
				default: ;
			endcase
		end
	end

	// flow magnitude, upstream end and case selection
	always_comb begin
		flow_u   = link_flow;
		neg      = flow_u[QW];
		flow_abs = neg ? (~flow_u + {{QW{1'b0}}, 1'b1}) : flow_u;
		q_in     = flow_abs[QW] ? lqmdu_pkg::QTY_MAX : flow_abs[QW-1:0];
		cup_in   = neg ? conc_end_two : conc_end_one;
		if (steady_mode_q) begin
			cs_in = lqmdu_pkg::CASE_STEADY;
		end else if (q_in == '0) begin
			cs_in = lqmdu_pkg::CASE_NOFLOW;
		end else if (link_volume_new <= zero_volume_q) begin
			cs_in = lqmdu_pkg::CASE_DRY;
		end else begin
			cs_in = lqmdu_pkg::CASE_MIX;
		end
	end

	// valid bits of the front and middle stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s5 <= e_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// stage 1: evaporation volume and decay partial products
	always_ff @(posedge clk) begin
		cs_s1      <= cs_in;
		q_s1       <= q_in;
		cup_s1     <= cup_in;
		csel_s1    <= steady_mode_q ? cup_in : link_conc_old;
		vold_s1    <= link_volume_old;
		diff_s1    <= link_volume_new - link_volume_old;
		grow_en_s1 <= (link_volume_new > link_volume_old);
		vold_gt_s1 <= (link_volume_old > zero_volume_q);
		knz_s1     <= (decay_rate != '0);
		epl_s1     <= evap_loss[HW-1:0] * time_step_q;
		eph_s1     <= evap_loss[QW-1:HW] * time_step_q;
		kdt_s1     <= decay_rate * time_step_q;
		sdec_s1    <= steady_decay;
	end

	// stage 2 logic: sum evaporation halves, form decay factor
	always_comb begin
		ev_full = ((QW+DW)'(eph_s1) << HW) + (QW+DW)'(epl_s1);
		vevap_c = (ev_full[QW+DW-1:QW+lqmdu_pkg::DT_FRAC] != '0) ? lqmdu_pkg::QTY_MAX
			: ev_full[QW+lqmdu_pkg::DT_FRAC-1:lqmdu_pkg::DT_FRAC];
		kdt_c   = kdt_s1[2*RW-1:lqmdu_pkg::DT_FRAC];
		dfac_c  = (kdt_c[2*RW-lqmdu_pkg::DT_FRAC-1:RW] != '0) ? '0
			: (lqmdu_pkg::RATE_ONE - FW'(kdt_c[RW-1:0]));
	end

	always_ff @(posedge clk) begin
		cs_s2       <= cs_s1;
		q_s2        <= q_s1;
		cup_s2      <= cup_s1;
		csel_s2     <= csel_s1;
		vold_s2     <= vold_s1;
		diff_s2     <= diff_s1;
		grow_en_s2  <= grow_en_s1;
		vevap_s2    <= vevap_c;
		use_evap_s2 <= vold_gt_s1 && (vevap_c != '0);
		dfac_s2     <= dfac_c;
		knz_s2      <= knz_s1;
		sdec_s2     <= sdec_s1;
	end

	// stage 3: concentration times evaporation volume, two halves
	always_ff @(posedge clk) begin
		cs_s3       <= cs_s2;
		q_s3        <= q_s2;
		cup_s3      <= cup_s2;
		csel_s3     <= csel_s2;
		vold_s3     <= vold_s2;
		diff_s3     <= diff_s2;
		grow_en_s3  <= grow_en_s2;
		use_evap_s3 <= use_evap_s2;
		dfac_s3     <= dfac_s2;
		knz_s3      <= knz_s2;
		sdec_s3     <= sdec_s2;
		cvl_s3      <= csel_s2[HW-1:0] * vevap_s2;
		cvh_s3      <= csel_s2[QW-1:HW] * vevap_s2;
	end

	// divider operands
	always_comb begin
		e_num              = ((2*QW)'(cvh_s3) << HW) + (2*QW)'(cvl_s3);
		g_num              = {diff_s3, 16'h0000};
		e_side_in.cs       = cs_s3;
		e_side_in.cup      = cup_s3;
		e_side_in.csel     = csel_s3;
		e_side_in.vold     = vold_s3;
		e_side_in.use_evap = use_evap_s3;
		e_side_in.dfac     = dfac_s3;
		e_side_in.knz      = knz_s3;
		e_side_in.sdec     = sdec_s3;
		g_side_in.q        = q_s3;
		g_side_in.grow_en  = grow_en_s3;
	end

	// evaporation quotient c*vevap/vold
	lqmdu_div #(
		.NUM_W  (2*QW),
		.DEN_W  (QW),
		.QUO_W  (QW),
		.SIDE_W ($bits(side_e_t))
	) u_div_evap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.num       (e_num),
		.den       (vold_s3),
		.side_in   (e_side_in),
		.out_valid (e_valid),
		.quo       (e_quo),
		.side_out  (e_side_out)
	);

	// volume growth rate (dv << 16)/dt; a zero step saturates
	lqmdu_div #(
		.NUM_W  (QW + 16),
		.DEN_W  (DW),
		.QUO_W  (QW),
		.SIDE_W ($bits(side_g_t))
	) u_div_grow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.num       (g_num),
		.den       (time_step_q),
		.side_in   (g_side_in),
		.out_valid (g_valid),
		.quo       (g_quo),
		.side_out  (g_side_out)
	);

	// stage 5: evaporated concentration and inflow rate
	always_ff @(posedge clk) begin
		cs_s5   <= e_side_out.cs;
		c1_s5   <= e_side_out.use_evap ? add_sat(e_side_out.csel, e_quo) : e_side_out.csel;
		qin_s5  <= g_side_out.grow_en ? add_sat(g_side_out.q, g_quo) : g_side_out.q;
		cup_s5  <= e_side_out.cup;
		vold_s5 <= e_side_out.vold;
		dfac_s5 <= e_side_out.dfac;
		knz_s5  <= e_side_out.knz;
		sdec_s5 <= e_side_out.sdec;
	end

	// stage 6: decay and inflow volume partial products
	assign fac_c = steady_mode_q ? FW'(sdec_s5) : dfac_s5;

	always_ff @(posedge clk) begin
		cs_s6   <= cs_s5;
		c1_s6   <= c1_s5;
		cup_s6  <= cup_s5;
		vold_s6 <= vold_s5;
		knz_s6  <= knz_s5;
		cpl_s6  <= c1_s5[HW-1:0] * fac_c;
		cph_s6  <= c1_s5[QW-1:HW] * fac_c;
		qpl_s6  <= qin_s5[HW-1:0] * time_step_q;
		qph_s6  <= qin_s5[QW-1:HW] * time_step_q;
	end

	// stage 7: decayed concentration and inflow volume, saturated
	always_comb begin
		cp_full = ((QW+FW)'(cph_s6) << HW) + (QW+FW)'(cpl_s6);
		qp_full = ((QW+DW)'(qph_s6) << HW) + (QW+DW)'(qpl_s6);
	end

	always_ff @(posedge clk) begin
		cs_s7   <= cs_s6;
		c1_s7   <= c1_s6;
		cup_s7  <= cup_s6;
		vold_s7 <= vold_s6;
		knz_s7  <= knz_s6;
		c2_s7   <= cp_full[QW+FW-1] ? lqmdu_pkg::QTY_MAX
			: cp_full[QW+lqmdu_pkg::RATE_FRAC-1:lqmdu_pkg::RATE_FRAC];
		vin_s7  <= (qp_full[QW+DW-1:QW+lqmdu_pkg::DT_FRAC] != '0) ? lqmdu_pkg::QTY_MAX
			: qp_full[QW+lqmdu_pkg::DT_FRAC-1:lqmdu_pkg::DT_FRAC];
	end

	// stage 8: mixing partial products, denominator and the non-mixing result
	always_comb begin
		case (cs_s7)
			lqmdu_pkg::CASE_STEADY: early_c = knz_s7 ? c2_s7 : c1_s7;
			lqmdu_pkg::CASE_NOFLOW: early_c = c2_s7;
			default:                early_c = cup_s7;
		endcase
	end

	always_ff @(posedge clk) begin
		cs_s8    <= cs_s7;
		early_s8 <= early_c;
		denom_s8 <= {1'b0, vold_s7} + {1'b0, vin_s7};
		pal_s8   <= c2_s7[HW-1:0] * vold_s7;
		pah_s8   <= c2_s7[QW-1:HW] * vold_s7;
		pbl_s8   <= cup_s7[HW-1:0] * vin_s7;
		pbh_s8   <= cup_s7[QW-1:HW] * vin_s7;
	end

	// stage 9: product sums, empty-denominator check
	always_ff @(posedge clk) begin
		cs_s9        <= cs_s8;
		early_s9     <= early_s8;
		denom_s9     <= denom_s8;
		use_early_s9 <= (cs_s8 != lqmdu_pkg::CASE_MIX) || (denom_s8 <= {1'b0, zero_volume_q});
		pa_s9        <= ((2*QW)'(pah_s8) << HW) + (2*QW)'(pal_s8);
		pb_s9        <= ((2*QW)'(pbh_s8) << HW) + (2*QW)'(pbl_s8);
	end

	always_comb begin
		m_num               = {1'b0, pa_s9} + {1'b0, pb_s9};
		m_side_in.cs        = cs_s9;
		m_side_in.early     = early_s9;
		m_side_in.use_early = use_early_s9;
	end

	// mixed concentration (c2*vold + cup*vin)/denom
	lqmdu_div #(
		.NUM_W  (2*QW + 1),
		.DEN_W  (QW + 1),
		.QUO_W  (QW),
		.SIDE_W ($bits(side_m_t))
	) u_div_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.num       (m_num),
		.den       (denom_s9),
		.side_in   (m_side_in),
		.out_valid (m_valid),
		.quo       (m_quo),
		.side_out  (m_side_out)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= m_valid;
		end
	end

	always_ff @(posedge clk) begin
		conc_q <= m_side_out.use_early ? m_side_out.early : m_quo;
		case_q <= m_side_out.cs;
	end

	assign done          = done_q;
	assign link_conc_new = conc_q;
	assign case_taken    = case_q;

	// the two front dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid == g_valid)
		else $error("growth and evaporation dividers out of step");

	// a transaction leaving the front dividers moves on through the middle stages
	a_mid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid |=> v_s5 ##4 v_s9)
		else $error("transaction lost between dividers");

	// every mixing quotient becomes a result strobe
	a_out_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid |=> done)
		else $error("mixing divider result not delivered");

endmodule

@@ test/link_quality_mix_decay_update_checker.sv @@
// checker for the link quality update: predicts each result and compares it
`timescale 1ns / 1ps

module link_quality_mix_decay_update_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [lqmdu_pkg::FLOW_W-1:0] link_flow,
	input  logic [lqmdu_pkg::QTY_W-1:0]         link_volume_old,
	input  logic [lqmdu_pkg::QTY_W-1:0]         link_volume_new,
	input  logic [lqmdu_pkg::QTY_W-1:0]         link_conc_old,
	input  logic [lqmdu_pkg::QTY_W-1:0]         conc_end_one,
	input  logic [lqmdu_pkg::QTY_W-1:0]         conc_end_two,
	input  logic [lqmdu_pkg::RATE_W-1:0]        decay_rate,
	input  logic [lqmdu_pkg::QTY_W-1:0]         evap_loss,
	input  logic [lqmdu_pkg::RATE_W-1:0]        steady_decay,
	input  logic                                done,
	input  logic [lqmdu_pkg::QTY_W-1:0]         link_conc_new,
	input  logic [1:0]                          case_taken,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [lqmdu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lqmdu_pkg::CFG_DAT_W-1:0]     cfg_data,
	output int                                  errors,
	output int                                  pending
);

	typedef struct packed {
		logic [lqmdu_pkg::QTY_W-1:0] conc;
		lqmdu_pkg::case_t            route;
	} conc_result_t;

	conc_result_t                  conc_expected[$];
	logic [lqmdu_pkg::DT_W-1:0]    step_reg;
	logic                          steady_reg;
	logic [lqmdu_pkg::QTY_W-1:0]   empty_reg;

	function automatic logic [127:0] sat_q(input logic [127:0] x);
		return (x > 128'(lqmdu_pkg::QTY_MAX)) ? 128'(lqmdu_pkg::QTY_MAX) : x;
	endfunction

	// evaporation concentrates the contents when the old volume is not empty
	function automatic logic [127:0] evaporate(input logic [127:0] c, input logic [127:0] vevap,
			input logic [127:0] vold, input logic use_it);
		if (!use_it)
			return c;
		return sat_q(c + sat_q((c * vevap) / vold));
	endfunction

	// new concentration for one link and pollutant
	function automatic conc_result_t mix_decay(
			input logic signed [lqmdu_pkg::FLOW_W-1:0] flow,
			input logic [127:0] vold, input logic [127:0] vnew, input logic [127:0] cold,
			input logic [127:0] c_one, input logic [127:0] c_two, input logic [127:0] k,
			input logic [127:0] evap, input logic [127:0] sdec);
		conc_result_t   r;
		logic [127:0]   q, cup, ts, zv, vevap, kdt, dfac, c1, c2, qin, grow, vin, denom, res;
		logic           use_evap;
		ts  = 128'(step_reg);
		zv  = 128'(empty_reg);
		q   = flow[lqmdu_pkg::FLOW_W-1] ? sat_q({87'b0, -flow}) : {87'b0, flow};
		cup = flow[lqmdu_pkg::FLOW_W-1] ? c_two : c_one;
		vevap    = sat_q((evap * ts) >> lqmdu_pkg::DT_FRAC);
		use_evap = (vold > zv) && (vevap != 0);
		kdt  = (k * ts) >> lqmdu_pkg::DT_FRAC;
		dfac = (kdt >= 128'(lqmdu_pkg::RATE_ONE)) ? 128'(0)
			: 128'(lqmdu_pkg::RATE_ONE) - kdt;
		if (steady_reg) begin
			c1 = evaporate(cup, vevap, vold, use_evap);
			res     = (k != 0) ? sat_q((c1 * sdec) >> lqmdu_pkg::RATE_FRAC) : c1;
			r.route = lqmdu_pkg::CASE_STEADY;
		end else if (q == 0) begin
			c1 = evaporate(cold, vevap, vold, use_evap);
			res     = sat_q((c1 * dfac) >> lqmdu_pkg::RATE_FRAC);
			r.route = lqmdu_pkg::CASE_NOFLOW;
		end else if (vnew <= zv) begin
			res     = cup;
			r.route = lqmdu_pkg::CASE_DRY;
		end else begin
			qin = q;
			if (vnew > vold) begin
				grow = (ts == 0) ? 128'(lqmdu_pkg::QTY_MAX)
					: sat_q(((vnew - vold) << lqmdu_pkg::DT_FRAC) / ts);
				qin  = sat_q(qin + grow);
			end
			vin   = sat_q((qin * ts) >> lqmdu_pkg::DT_FRAC);
			denom = vold + vin;
			if (denom <= zv) begin
				res = cup;
			end else begin
				c1 = evaporate(cold, vevap, vold, use_evap);
				c2 = sat_q((c1 * dfac) >> lqmdu_pkg::RATE_FRAC);
				res = sat_q((c2 * vold + cup * vin) / denom);
			end
			r.route = lqmdu_pkg::CASE_MIX;
		end
		r.conc = res[lqmdu_pkg::QTY_W-1:0];
		return r;
	endfunction

	assign pending = conc_expected.size();

	// follow register writes, predict accepted items, check results
	always @(posedge clk or negedge arst_n) begin
		conc_result_t want;
		int           bad;
		bad = 0;
		if (!arst_n) begin
			step_reg   <= lqmdu_pkg::RST_TIME_STEP;
			steady_reg <= 1'b0;
			empty_reg  <= lqmdu_pkg::RST_ZERO_VOLUME;
			errors     <= 0;
			conc_expected.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (lqmdu_pkg::reg_idx_t'(cfg_index))
					lqmdu_pkg::REG_TIME_STEP:   step_reg   <= cfg_data[lqmdu_pkg::DT_W-1:0];
					lqmdu_pkg::REG_STEADY_MODE: steady_reg <= cfg_data[0];
					lqmdu_pkg::REG_ZERO_VOLUME: empty_reg  <= cfg_data[lqmdu_pkg::QTY_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				conc_expected.push_back(mix_decay(link_flow, 128'(link_volume_old),
					128'(link_volume_new), 128'(link_conc_old), 128'(conc_end_one),
					128'(conc_end_two), 128'(decay_rate), 128'(evap_loss),
					128'(steady_decay)));
			if (done) begin
				if (conc_expected.size() == 0) begin
					$display("%0t: unexpected result conc %h case %0d", $time,
						link_conc_new, case_taken);
					bad = bad + 1;
				end else begin
					want = conc_expected.pop_front();
					if (link_conc_new !== want.conc) begin
						$display("%0t: link_conc_new expected %h actual %h", $time,
							want.conc, link_conc_new);
						bad = bad + 1;
					end
					if (case_taken !== want.route) begin
						$display("%0t: case_taken expected %0d actual %0d", $time,
							want.route, case_taken);
						bad = bad + 1;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
		end
	end

endmodule

@@ test/testbench.sv @@
// stimulus and verdict for the link quality mix and decay update block
`timescale 1ns / 1ps

module testbench;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 120;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic signed [lqmdu_pkg::FLOW_W-1:0] link_flow = '0;
	logic [lqmdu_pkg::QTY_W-1:0]         link_volume_old = '0;
	logic [lqmdu_pkg::QTY_W-1:0]         link_volume_new = '0;
	logic [lqmdu_pkg::QTY_W-1:0]         link_conc_old = '0;
	logic [lqmdu_pkg::QTY_W-1:0]         conc_end_one = '0;
	logic [lqmdu_pkg::QTY_W-1:0]         conc_end_two = '0;
	logic [lqmdu_pkg::RATE_W-1:0]        decay_rate = '0;
	logic [lqmdu_pkg::QTY_W-1:0]         evap_loss = '0;
	logic [lqmdu_pkg::RATE_W-1:0]        steady_decay = '0;
	logic                                done;
	logic [lqmdu_pkg::QTY_W-1:0]         link_conc_new;
	logic [1:0]                          case_taken;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [lqmdu_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [lqmdu_pkg::CFG_DAT_W-1:0]     cfg_data = '0;
	int                                  errors;
	int                                  pending;
	int                                  idle_cycles = 0;
	logic [lqmdu_pkg::QTY_W-1:0]         empty_now = lqmdu_pkg::RST_ZERO_VOLUME;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	link_quality_mix_decay_update_top u_dut (.*);

	link_quality_mix_decay_update_checker u_checker (.*);

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// quantity with a spread of magnitudes and the extremes
	function automatic logic [lqmdu_pkg::QTY_W-1:0] pick_qty();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return lqmdu_pkg::QTY_MAX;
			2, 3: return r[lqmdu_pkg::QTY_W-1:0];
			default: return r[lqmdu_pkg::QTY_W-1:0] >> $urandom_range(8, 39);
		endcase
	endfunction

	function automatic logic [lqmdu_pkg::RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return $urandom();
			default: return $urandom() >> $urandom_range(4, 31);
		endcase
	endfunction

	task automatic wait_gap();
		int gap;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: gap = 0;
			5, 6, 7, 8: gap = $urandom_range(1, 3);
			default: gap = $urandom_range(10, 40);
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one transaction into the pipeline, then a random gap
	task automatic send_link(input logic signed [lqmdu_pkg::FLOW_W-1:0] flow,
			input logic [lqmdu_pkg::QTY_W-1:0] vold,
			input logic [lqmdu_pkg::QTY_W-1:0] vnew, input logic [lqmdu_pkg::QTY_W-1:0] cold,
			input logic [lqmdu_pkg::QTY_W-1:0] c_one, input logic [lqmdu_pkg::QTY_W-1:0] c_two,
			input logic [lqmdu_pkg::RATE_W-1:0] k, input logic [lqmdu_pkg::QTY_W-1:0] evap,
			input logic [lqmdu_pkg::RATE_W-1:0] sdec);
		start           <= 1'b1;
		link_flow       <= flow;
		link_volume_old <= vold;
		link_volume_new <= vnew;
		link_conc_old   <= cold;
		conc_end_one    <= c_one;
		conc_end_two    <= c_two;
		decay_rate      <= k;
		evap_loss       <= evap;
		steady_decay    <= sdec;
		do
			@(posedge clk);
		while (busy);
		wait_gap();
	endtask

	task automatic send_random();
		logic [lqmdu_pkg::QTY_W-1:0]         mag;
		logic signed [lqmdu_pkg::FLOW_W-1:0] flow;
		mag  = pick_qty();
		flow = $urandom_range(0, 1) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if ($urandom_range(0, 30) == 0)
			flow = {1'b1, {lqmdu_pkg::QTY_W{1'b0}}};
		send_link(flow, pick_qty(), pick_qty(), pick_qty(), pick_qty(), pick_qty(),
			pick_rate(), pick_qty(), pick_rate());
	endtask

	// register write while the pipeline is drained
	task automatic write_reg(input lqmdu_pkg::reg_idx_t idx,
			input logic [lqmdu_pkg::CFG_DAT_W-1:0] value);
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == lqmdu_pkg::REG_ZERO_VOLUME)
			empty_now = value;
	endtask

	task automatic directed_links();
		logic [lqmdu_pkg::QTY_W-1:0] one;
		logic [lqmdu_pkg::QTY_W-1:0] full;
		one  = 40'h1_0000;
		full = lqmdu_pkg::QTY_MAX;
		// no flow with decay and evaporation
		send_link('0, 40'h10_0000, 40'h10_0000, 40'h5_0000, one, one, 32'h100_0000,
			40'h8000, 32'h8000_0000);
		// dry link, both flow directions
		send_link(41'sh1_0000, 40'h10_0000, '0, one, 40'h3_0000, 40'h7_0000, '0, '0, '0);
		send_link(-41'sh1_0000, 40'h10_0000, '0, one, 40'h3_0000, 40'h7_0000, '0, '0, '0);
		// mixing with growing and shrinking volume
		send_link(41'sh2_0000, 40'h10_0000, 40'h20_0000, 40'h4_0000, 40'h9_0000,
			40'h1_0000, 32'h1000_0000, 40'h100, 32'h1234_5678);
		send_link(-41'sh2_0000, 40'h20_0000, 40'h10_0000, 40'h4_0000, 40'h9_0000,
			40'h1_0000, '1, full, '1);
		// most negative flow and full-scale fields
		send_link({1'b1, {lqmdu_pkg::QTY_W{1'b0}}}, full, full, full, full, full, '1,
			full, '1);
		send_link({1'b0, full}, full, full, full, full, full, '1, full, '1);
		send_link(-41'sd1, '0, full, '0, '0, full, '0, '0, '0);
		// tiny mixing volume that may fall under the empty threshold
		send_link(41'sd1, '0, empty_now + 1, one, 40'h2_0000, one, '0, '0, '0);
		send_link(41'sd1, '0, '0, '0, '0, '0, '0, '0, '0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults, then all registers across their ranges
		directed_links();
		repeat (60) send_random();
		write_reg(lqmdu_pkg::REG_TIME_STEP, 40'd1);
		write_reg(lqmdu_pkg::REG_ZERO_VOLUME, 40'd0);
		directed_links();
		repeat (60) send_random();
		write_reg(lqmdu_pkg::REG_TIME_STEP, 40'hFFFF_FFFF);
		write_reg(lqmdu_pkg::REG_ZERO_VOLUME, lqmdu_pkg::QTY_MAX);
		repeat (40) send_random();
		write_reg(lqmdu_pkg::REG_TIME_STEP, 40'd3);
		write_reg(lqmdu_pkg::REG_ZERO_VOLUME, 40'd2314);
		directed_links();
		repeat (60) send_random();
		write_reg(lqmdu_pkg::REG_STEADY_MODE, 40'd1);
		directed_links();
		repeat (50) send_random();
		write_reg(lqmdu_pkg::REG_TIME_STEP, 40'hFFFF_FFFF);
		repeat (40) send_random();
		write_reg(lqmdu_pkg::REG_STEADY_MODE, 40'd0);
		write_reg(lqmdu_pkg::REG_TIME_STEP, {8'b0, $urandom()});
		write_reg(lqmdu_pkg::REG_ZERO_VOLUME, {$urandom(), 8'b0} >> $urandom_range(8, 39));
		repeat (80) send_random();
		start <= 1'b0;

		// drain and give the verdict
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
